// ===== hdl/assert_macros.svh =====
// assertion macros shared by the congestion window block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TNR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// expression must never be true at a clock edge outside reset
`define TNR_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== hdl/tnr_pkg.sv =====
// shared widths, codes and types for the congestion window block
package tnr_pkg;

    // field widths
    localparam int unsigned REQ_W  = 2;
    localparam int unsigned SEQ_W  = 32;
    localparam int unsigned DUPS_W = 16;
    localparam int unsigned MSS_W  = 16;
    localparam int unsigned WIN_W  = 32;

    // defaults for the top level parameters
    localparam int unsigned DUP_ACK_THRESHOLD_DEF = 3;
    localparam int unsigned DEFAULT_SEGMENT_DEF   = 536;

    // segment size register after reset
    localparam logic [MSS_W-1:0] MSS_RESET = MSS_W'(536);

    // window saturation value
    localparam logic [WIN_W-1:0] WIN_ALL_ONES = '1;

    // event codes
    localparam logic [REQ_W-1:0] REQ_ACK     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EST     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

// ===== hdl/tnr_mul.sv =====
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
`include "assert_macros.svh"

module tnr_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tnr_pkg::MSS_W-1:0]     mcand,
    input  logic [tnr_pkg::MSS_W-1:0]     mplier,
    output logic [2*tnr_pkg::MSS_W-1:0]   product,
    output tnr_pkg::unit_sts_t            sts
);

    localparam int unsigned MW    = tnr_pkg::MSS_W;
    localparam int unsigned CNT_W = $clog2(MW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MW-1:0]     hi_reg, hi_next;
    logic [MW-1:0]     lo_reg, lo_next;
    logic [MW-1:0]     mcand_reg, mcand_next;
    logic [MW:0]       sum;

    // partial sum of the upper half and the selected multiplicand
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    // next step of the shift and add
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mcand_next = mcand_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(MW - 1);
            hi_next    = '0;
            lo_next    = mplier;
            mcand_next = mcand;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[MW:1];
            lo_next  = {sum[0], lo_reg[MW-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // data shift registers
    always_ff @(posedge clk)
    begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mcand_reg <= mcand_next;
    end

    assign product  = {hi_reg, lo_reg};
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

    // done only at the end of a run
    `TNR_ASSERT(a_mul_done_ends_run, clk, rst_n, done_reg |-> $fell(busy_reg), "multiplier done without a run")

endmodule

// ===== hdl/tnr_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`include "assert_macros.svh"

module tnr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tnr_pkg::WIN_W-1:0]   dividend,
    input  logic [tnr_pkg::WIN_W-1:0]   divisor,
    output logic [tnr_pkg::WIN_W-1:0]   quotient,
    output tnr_pkg::unit_sts_t          sts
);

    localparam int unsigned W     = tnr_pkg::WIN_W;
    localparam int unsigned CNT_W = $clog2(W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      quo_reg, quo_next;
    logic [W-1:0]      divisor_reg, divisor_next;
    logic [W:0]        shifted;
    logic [W+1:0]      diff;
    logic              fits;

    // trial subtraction of the divisor from the shifted remainder
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor_reg};
    assign fits    = !diff[W+1];

    // next step of the division
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = CNT_W'(W - 1);
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // data shift registers
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign quotient = quo_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

    // partial remainder stays below a nonzero divisor
    `TNR_ASSERT(a_div_rem_bound, clk, rst_n, busy_reg && (divisor_reg != '0) |-> (rem_reg < divisor_reg), "divider remainder out of range")

endmodule

// ===== hdl/tcp_newreno_congestion_window.sv =====
// congestion window, slow-start threshold and fast recovery of one connection
// - input channel: in_valid / in_stall with one event beat (req_type and the
//   ack, window and sequence fields); one beat is taken at a time, in_stall
//   stays high from acceptance until the result has been placed in the
//   output register
// - output channel: out_valid / out_stall with the window, threshold,
//   recovery and retransmit fields after the event; the output register
//   holds a stalled beat while the next event is already being worked on
// - configuration: cfg_write_en writes cfg_write_data into the segment size
//   register; write only while no event is in flight
// - sequencing: an accepted event passes the decide, update and out states
//   on its way to the output register; congestion avoidance adds the serial
//   multiplier (segment size squared) and then the serial divider (by the
//   window) between decide and update, one bit per cycle each
// - reset: window two default segments, threshold all ones, recovery off,
//   segment size 536; no clearing pass
// - receiver stall: a finished result waits in the output register; the
//   next event is accepted but its result waits until the register is free
`include "assert_macros.svh"

module tcp_newreno_congestion_window #(
    parameter int unsigned DUP_ACK_THRESHOLD = tnr_pkg::DUP_ACK_THRESHOLD_DEF,
    parameter int unsigned DEFAULT_SEGMENT   = tnr_pkg::DEFAULT_SEGMENT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_write_en,
    input  logic [tnr_pkg::MSS_W-1:0]     cfg_write_data,
    // event channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tnr_pkg::REQ_W-1:0]     req_type,
    input  logic [tnr_pkg::SEQ_W-1:0]     ack_number,
    input  logic [tnr_pkg::SEQ_W-1:0]     prev_ack_number,
    input  logic [tnr_pkg::DUPS_W-1:0]    dup_ack_count,
    input  logic [tnr_pkg::WIN_W-1:0]     peer_window,
    input  logic [tnr_pkg::SEQ_W-1:0]     send_next_seq,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tnr_pkg::WIN_W-1:0]     cong_window,
    output logic [tnr_pkg::WIN_W-1:0]     slow_start_thresh,
    output logic                          in_recovery,
    output logic                          retransmit,
    output logic [tnr_pkg::WIN_W-1:0]     usable_window
);

    localparam int unsigned MSS_W  = tnr_pkg::MSS_W;
    localparam int unsigned WIN_W  = tnr_pkg::WIN_W;
    localparam int unsigned SEQ_W  = tnr_pkg::SEQ_W;
    localparam int unsigned DUPS_W = tnr_pkg::DUPS_W;
    localparam int unsigned REQ_W  = tnr_pkg::REQ_W;
    localparam int unsigned THR_W  = $clog2(DUP_ACK_THRESHOLD + 1);
    localparam int unsigned TM_W   = MSS_W + THR_W;

    localparam logic [DUPS_W-1:0] DUP_THR  = DUPS_W'(DUP_ACK_THRESHOLD);
    localparam logic [MSS_W-1:0]  DEF_SEG  = MSS_W'(DEFAULT_SEGMENT);
    localparam logic [WIN_W-1:0]  CWND_RST = WIN_W'(2 * DEFAULT_SEGMENT);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_MUL    = 6'b000100,
        S_DIV    = 6'b001000,
        S_UPDATE = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ADD_MSS,
        ACT_EXIT,
        ACT_AVOID,
        ACT_THIRD,
        ACT_EST,
        ACT_TIMEOUT
    } act_t;

    state_t               state_reg, state_next;
    act_t                 act_reg, act_next;
    logic                 rtx_reg, rtx_next;

    // accepted event
    logic [REQ_W-1:0]     req_reg;
    logic [SEQ_W-1:0]     ack_reg;
    logic [SEQ_W-1:0]     prev_reg;
    logic [DUPS_W-1:0]    dups_reg;
    logic [WIN_W-1:0]     peer_reg;
    logic [SEQ_W-1:0]     snd_nxt_reg;

    // connection state
    logic [MSS_W-1:0]     mss_reg, mss_next;
    logic [WIN_W-1:0]     cwnd_reg, cwnd_next;
    logic [WIN_W-1:0]     ssth_reg, ssth_next;
    logic                 recov_reg, recov_next;
    logic [SEQ_W-1:0]     end_reg, end_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [WIN_W-1:0]     cwnd_out_reg;
    logic [WIN_W-1:0]     ssth_out_reg;
    logic                 recov_out_reg;
    logic                 rtx_out_reg;
    logic [WIN_W-1:0]     usable_out_reg;

    logic                 in_take;
    logic                 out_load;
    logic [SEQ_W-1:0]     ack_gap;
    logic                 peer_nz;
    logic [WIN_W-1:0]     half;
    logic [TM_W-1:0]      thr_mss;
    logic [WIN_W-1:0]     add_a;
    logic [WIN_W-1:0]     add_b;
    logic [WIN_W:0]       add_sum;
    logic [WIN_W-1:0]     sat_sum;
    logic [WIN_W-1:0]     inc;
    logic [MSS_W-1:0]     mss_eff;
    logic [WIN_W-1:0]     usable;

    logic                 mul_start;
    logic                 div_start;
    logic [2*MSS_W-1:0]   mss_sq;
    logic [WIN_W-1:0]     quotient;
    tnr_pkg::unit_sts_t   mul_sts;
    tnr_pkg::unit_sts_t   div_sts;

    // conditions watched by the checks
    logic                 unit_restart;
    logic                 out_clobber;
    logic                 third_upd;
    logic                 recov_ok;

    // handshakes
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // event decision on the latched beat
    assign ack_gap = ack_reg - end_reg;
    assign peer_nz = (peer_reg != '0);

    always_comb
    begin
        act_next = ACT_NONE;
        rtx_next = 1'b0;
        case (req_reg)
            tnr_pkg::REQ_ACK:
            begin
                if (dups_reg == '0)
                begin
                    if (ack_reg != prev_reg)
                    begin
                        if (cwnd_reg <= ssth_reg)
                        begin
                            act_next = ACT_ADD_MSS;
                        end
                        else if (recov_reg)
                        begin
                            if (!ack_gap[SEQ_W-1])
                            begin
                                act_next = ACT_EXIT;
                            end
                            else
                            begin
                                rtx_next = peer_nz;
                            end
                        end
                        else
                        begin
                            act_next = ACT_AVOID;
                        end
                    end
                end
                else if (dups_reg >= DUP_THR)
                begin
                    act_next = (dups_reg == DUP_THR) ? ACT_THIRD : ACT_ADD_MSS;
                    rtx_next = peer_nz;
                end
            end
            tnr_pkg::REQ_EST:
            begin
                act_next = ACT_EST;
            end
            tnr_pkg::REQ_TIMEOUT:
            begin
                act_next = ACT_TIMEOUT;
            end
            default:
            begin
                act_next = ACT_NONE;
            end
        endcase
    end

    // serial units for the congestion avoidance increase
    assign mul_start = (state_reg == S_DECIDE) && (act_next == ACT_AVOID);
    assign div_start = (state_reg == S_MUL) && mul_sts.done;

    tnr_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mss_reg),
        .mplier  (mss_reg),
        .product (mss_sq),
        .sts     (mul_sts)
    );

    tnr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (WIN_W'(mss_sq)),
        .divisor  (cwnd_reg),
        .quotient (quotient),
        .sts      (div_sts)
    );

    // shared saturating adder for window growth
    assign half    = cwnd_reg >> 1;
    assign thr_mss = TM_W'(DUP_ACK_THRESHOLD) * TM_W'(mss_reg);
    assign inc     = (quotient == '0) ? WIN_W'(1) : quotient;
    assign add_a   = (act_reg == ACT_THIRD) ? half : cwnd_reg;

    always_comb
    begin
        case (act_reg)
            ACT_ADD_MSS: add_b = WIN_W'(mss_reg);
            ACT_THIRD:   add_b = WIN_W'(thr_mss);
            ACT_AVOID:   add_b = inc;
            default:     add_b = '0;
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b};
    assign sat_sum = add_sum[WIN_W] ? tnr_pkg::WIN_ALL_ONES : add_sum[WIN_W-1:0];
    assign mss_eff = (mss_reg == '0) ? DEF_SEG : mss_reg;

    // connection state update
    always_comb
    begin
        mss_next   = cfg_write_en ? cfg_write_data : mss_reg;
        cwnd_next  = cwnd_reg;
        ssth_next  = ssth_reg;
        recov_next = recov_reg;
        end_next   = end_reg;
        if (state_reg == S_UPDATE)
        begin
            case (act_reg)
                ACT_ADD_MSS, ACT_AVOID:
                begin
                    cwnd_next = sat_sum;
                end
                ACT_EXIT:
                begin
                    recov_next = 1'b0;
                    cwnd_next  = ssth_reg;
                end
                ACT_THIRD:
                begin
                    ssth_next  = half;
                    cwnd_next  = sat_sum;
                    recov_next = 1'b1;
                    end_next   = snd_nxt_reg;
                end
                ACT_EST:
                begin
                    ssth_next = peer_reg;
                    mss_next  = mss_eff;
                    cwnd_next = WIN_W'({mss_eff, 1'b0});
                end
                ACT_TIMEOUT:
                begin
                    ssth_next = half;
                    cwnd_next = WIN_W'(mss_reg);
                end
                default:
                begin
                    cwnd_next = cwnd_reg;
                end
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_take) state_next = S_DECIDE;
            S_DECIDE: state_next = (act_next == ACT_AVOID) ? S_MUL : S_UPDATE;
            S_MUL:    if (mul_sts.done) state_next = S_DIV;
            S_DIV:    if (div_sts.done) state_next = S_UPDATE;
            S_UPDATE: state_next = S_OUT;
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // output register valid
    assign out_valid_next = out_load || (out_valid_reg && out_stall);
    assign usable         = (cwnd_reg < peer_reg) ? cwnd_reg : peer_reg;

    // control and connection state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= ACT_NONE;
            rtx_reg       <= 1'b0;
            mss_reg       <= tnr_pkg::MSS_RESET;
            cwnd_reg      <= CWND_RST;
            ssth_reg      <= tnr_pkg::WIN_ALL_ONES;
            recov_reg     <= 1'b0;
            end_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (state_reg == S_DECIDE)
            begin
                act_reg <= act_next;
                rtx_reg <= rtx_next;
            end
            mss_reg       <= mss_next;
            cwnd_reg      <= cwnd_next;
            ssth_reg      <= ssth_next;
            recov_reg     <= recov_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input beat capture
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg     <= req_type;
            ack_reg     <= ack_number;
            prev_reg    <= prev_ack_number;
            dups_reg    <= dup_ack_count;
            peer_reg    <= peer_window;
            snd_nxt_reg <= send_next_seq;
        end
    end

    // output beat capture
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cwnd_out_reg   <= cwnd_reg;
            ssth_out_reg   <= ssth_reg;
            recov_out_reg  <= recov_reg;
            rtx_out_reg    <= rtx_reg;
            usable_out_reg <= usable;
        end
    end

    assign out_valid         = out_valid_reg;
    assign cong_window       = cwnd_out_reg;
    assign slow_start_thresh = ssth_out_reg;
    assign in_recovery       = recov_out_reg;
    assign retransmit        = rtx_out_reg;
    assign usable_window     = usable_out_reg;

    // conditions for the checks below
    assign unit_restart = (mul_start && mul_sts.busy) || (div_start && div_sts.busy);
    assign out_clobber  = out_load && out_valid_reg && out_stall;
    assign third_upd    = (state_reg == S_UPDATE) && (act_reg == ACT_THIRD);
    assign recov_ok     = recov_reg && (ssth_reg <= cwnd_reg);

    // serial units are only started when free
    `TNR_ASSERT_NEVER(a_unit_start_busy, clk, rst_n, unit_restart, "serial unit restarted")

    // a pending result beat is never overwritten
    `TNR_ASSERT_NEVER(a_out_overwrite, clk, rst_n, out_clobber, "output beat overwritten")

    // third duplicate enters recovery with the window at or above the threshold
    `TNR_ASSERT(a_third_dup, clk, rst_n, third_upd |=> recov_ok, "recovery not entered")

endmodule

// ===== verif/tb_tcp_newreno_congestion_window.sv =====
// testbench for the new reno congestion window block: directed and random events, scoreboard check
`timescale 1ns / 1ps

module tb_tcp_newreno_congestion_window;

    localparam int unsigned REQ_W         = tnr_pkg::REQ_W;
    localparam int unsigned SEQ_W         = tnr_pkg::SEQ_W;
    localparam int unsigned DUPS_W        = tnr_pkg::DUPS_W;
    localparam int unsigned MSS_W         = tnr_pkg::MSS_W;
    localparam int unsigned WIN_W         = tnr_pkg::WIN_W;
    localparam int unsigned DUP_TH        = tnr_pkg::DUP_ACK_THRESHOLD_DEF;
    localparam int unsigned DEF_SEG       = tnr_pkg::DEFAULT_SEGMENT_DEF;
    localparam logic [WIN_W-1:0] ALL_ONES = tnr_pkg::WIN_ALL_ONES;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned BIG_SEG_STEPS = 20;

    // one event beat as presented on the input channel
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [SEQ_W-1:0]  ack;
        logic [SEQ_W-1:0]  prev;
        logic [DUPS_W-1:0] dups;
        logic [WIN_W-1:0]  peer;
        logic [SEQ_W-1:0]  nxt;
    } tcp_ev_t;

    // one result beat
    typedef struct packed {
        logic [WIN_W-1:0] cwnd;
        logic [WIN_W-1:0] ssth;
        logic             recov;
        logic             rtx;
        logic [WIN_W-1:0] usable;
    } win_result_t;

    // window predictor and queue of windows still due from the block
    class cwnd_scoreboard;
        logic [MSS_W-1:0] mss;
        logic [WIN_W-1:0] cwnd;
        logic [WIN_W-1:0] ssthresh;
        logic             recov;
        logic [SEQ_W-1:0] end_seq;
        win_result_t      due_windows[$];
        int unsigned      n_beats;
        int unsigned      n_errors;

        function new();
            mss      = tnr_pkg::MSS_RESET;
            cwnd     = WIN_W'(2 * DEF_SEG);
            ssthresh = ALL_ONES;
            recov    = 1'b0;
            end_seq  = '0;
            n_beats  = 0;
            n_errors = 0;
        endfunction

        function void write_mss(logic [MSS_W-1:0] value);
            mss = value;
        endfunction

        // window increase clamped at all ones
        function logic [WIN_W-1:0] grow(logic [WIN_W-1:0] base, logic [63:0] inc);
            logic [63:0] sum;
            sum = 64'(base) + inc;
            return (sum > 64'(ALL_ONES)) ? ALL_ONES : sum[WIN_W-1:0];
        endfunction

        // advance the window state by one accepted event and queue its result
        function void note_event(tcp_ev_t ev);
            win_result_t      want;
            logic             rtx;
            logic [63:0]      inc;
            logic [SEQ_W-1:0] ahead;
            rtx = 1'b0;
            case (ev.req)
                tnr_pkg::REQ_ACK:
                begin
                    if (ev.dups == '0)
                    begin
                        if (ev.ack != ev.prev)
                        begin
                            if (cwnd <= ssthresh)
                                cwnd = grow(cwnd, 64'(mss));
                            else if (recov)
                            begin
                                // serial compare against the end of recovery
                                ahead = ev.ack - end_seq;
                                if (!ahead[SEQ_W-1])
                                begin
                                    recov = 1'b0;
                                    cwnd  = ssthresh;
                                end
                                rtx = recov && (ev.peer != '0);
                            end
                            else
                            begin
                                // congestion avoidance, at least one byte
                                inc = 64'd1;
                                if (cwnd != '0)
                                    inc = (64'(mss) * 64'(mss)) / 64'(cwnd);
                                if (inc == 64'd0)
                                    inc = 64'd1;
                                cwnd = grow(cwnd, inc);
                            end
                        end
                    end
                    else if (32'(ev.dups) >= DUP_TH)
                    begin
                        if (32'(ev.dups) == DUP_TH)
                        begin
                            ssthresh = cwnd >> 1;
                            cwnd     = grow(ssthresh, 64'(DUP_TH) * 64'(mss));
                            recov    = 1'b1;
                            end_seq  = ev.nxt;
                        end
                        else
                            cwnd = grow(cwnd, 64'(mss));
                        rtx = (ev.peer != '0);
                    end
                end
                tnr_pkg::REQ_EST:
                begin
                    ssthresh = ev.peer;
                    if (mss == '0)
                        mss = MSS_W'(DEF_SEG);
                    cwnd = WIN_W'(mss) << 1;
                end
                tnr_pkg::REQ_TIMEOUT:
                begin
                    ssthresh = cwnd >> 1;
                    cwnd     = WIN_W'(mss);
                end
                default: ;
            endcase
            want.cwnd   = cwnd;
            want.ssth   = ssthresh;
            want.recov  = recov;
            want.rtx    = rtx;
            want.usable = (cwnd < ev.peer) ? cwnd : ev.peer;
            due_windows.push_back(want);
        endfunction

        function void report_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch on beat %0d: %s expected %h got %h",
                         n_beats, what, exp_v, act_v);
        endfunction

        // compare one result beat with the oldest window due
        function void check_result(win_result_t got);
            win_result_t want;
            n_beats++;
            if (due_windows.size() == 0)
            begin
                report_mismatch("beat with nothing due", '0, got.cwnd);
                return;
            end
            want = due_windows.pop_front();
            if (got.cwnd !== want.cwnd)
                report_mismatch("cong_window", want.cwnd, got.cwnd);
            if (got.ssth !== want.ssth)
                report_mismatch("slow_start_thresh", want.ssth, got.ssth);
            if (got.recov !== want.recov)
                report_mismatch("in_recovery", 32'(want.recov), 32'(got.recov));
            if (got.rtx !== want.rtx)
                report_mismatch("retransmit", 32'(want.rtx), 32'(got.rtx));
            if (got.usable !== want.usable)
                report_mismatch("usable_window", want.usable, got.usable);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write_en;
    logic [MSS_W-1:0]   cfg_write_data;
    logic               in_valid;
    logic               in_stall;
    logic [REQ_W-1:0]   req_type;
    logic [SEQ_W-1:0]   ack_number;
    logic [SEQ_W-1:0]   prev_ack_number;
    logic [DUPS_W-1:0]  dup_ack_count;
    logic [WIN_W-1:0]   peer_window;
    logic [SEQ_W-1:0]   send_next_seq;
    logic               out_valid;
    logic               out_stall;
    logic [WIN_W-1:0]   cong_window;
    logic [WIN_W-1:0]   slow_start_thresh;
    logic               in_recovery;
    logic               retransmit;
    logic [WIN_W-1:0]   usable_window;

    cwnd_scoreboard     sb;
    win_result_t        seen_beat;
    bit                 idle_on;
    bit                 stall_on;
    int unsigned        n_events;
    int unsigned        quiet_cycles;
    logic [SEQ_W-1:0]   ack_mark;
    int unsigned        dup_run;

    always #1 clk = ~clk;

    tcp_newreno_congestion_window #(
        .DUP_ACK_THRESHOLD (DUP_TH),
        .DEFAULT_SEGMENT   (DEF_SEG)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .req_type          (req_type),
        .ack_number        (ack_number),
        .prev_ack_number   (prev_ack_number),
        .dup_ack_count     (dup_ack_count),
        .peer_window       (peer_window),
        .send_next_seq     (send_next_seq),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .cong_window       (cong_window),
        .slow_start_thresh (slow_start_thresh),
        .in_recovery       (in_recovery),
        .retransmit        (retransmit),
        .usable_window     (usable_window)
    );

    function automatic tcp_ev_t ev_of(logic [REQ_W-1:0] req, logic [SEQ_W-1:0] ack,
                                      logic [SEQ_W-1:0] prev, logic [DUPS_W-1:0] dups,
                                      logic [WIN_W-1:0] peer, logic [SEQ_W-1:0] nxt);
        tcp_ev_t ev;
        ev.req  = req;
        ev.ack  = ack;
        ev.prev = prev;
        ev.dups = dups;
        ev.peer = peer;
        ev.nxt  = nxt;
        return ev;
    endfunction

    // advertised window: mostly moderate, with zero, all ones and full range mixed in
    function automatic logic [WIN_W-1:0] pick_peer();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        else if (roll < 22)
            return $urandom();
        else if (roll < 27)
            return ALL_ONES;
        return $urandom_range(1, 400000);
    endfunction

    function automatic logic [REQ_W-1:0] rand_req_type();
        return REQ_W'($urandom_range(0, 3));
    endfunction

    // mostly well-formed ack streams with dup runs, plus noise and broken runs
    function automatic tcp_ev_t make_event();
        tcp_ev_t          ev;
        int unsigned      roll;
        logic [WIN_W-1:0] seg;
        seg = (sb.mss == '0) ? WIN_W'(DEF_SEG) : WIN_W'(sb.mss);
        ev = ev_of(tnr_pkg::REQ_ACK, ack_mark, ack_mark, '0, pick_peer(),
                   ack_mark + $urandom_range(0, 200000));
        roll = $urandom_range(0, 99);
        if (dup_run != 0)
        begin
            dup_run++;
            ev.dups = DUPS_W'(dup_run);
            if (dup_run < DUP_TH ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 2) == 0))
                dup_run = 0;
        end
        else if (roll < 5)
            ev = ev_of(rand_req_type(), $urandom(), $urandom(), DUPS_W'($urandom()),
                       $urandom(), $urandom());
        else if (roll < 9)
        begin
            ev.req = tnr_pkg::REQ_EST;
            case ($urandom_range(0, 3))
                0: ev.peer = seg * $urandom_range(1, 6);
                1: ev.peer = $urandom();
                2: ev.peer = '0;
                default: ev.peer = ALL_ONES;
            endcase
        end
        else if (roll < 12)
            ev.req = tnr_pkg::REQ_TIMEOUT;
        else if (roll < 14)
            ev = ev_of(REQ_UNKNOWN, $urandom(), $urandom(), DUPS_W'($urandom()),
                       $urandom(), $urandom());
        else if (roll < 28)
        begin
            dup_run = 1;
            ev.dups = DUPS_W'(1);
        end
        else if (roll >= 33)
        begin
            // new ack: partial or full in recovery, ordinary advance otherwise
            if (sb.recov && $urandom_range(0, 1) == 1)
            begin
                if ($urandom_range(0, 1) == 1)
                    ev.ack = sb.end_seq + $urandom_range(0, 3 * seg);
                else
                    ev.ack = sb.end_seq - $urandom_range(1, 100000);
            end
            else
                ev.ack = ack_mark + $urandom_range(1, 4 * seg);
            ack_mark = ev.ack;
        end
        return ev;
    endfunction

    // present one event beat and hold it until taken
    task automatic send_event(input tcp_ev_t ev);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid        <= 1'b1;
        req_type        <= ev.req;
        ack_number      <= ev.ack;
        prev_ack_number <= ev.prev;
        dup_ack_count   <= ev.dups;
        peer_window     <= ev.peer;
        send_next_seq   <= ev.nxt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_event(ev);
        n_events++;
    endtask

    // drop valid and wait until every due window has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.due_windows.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mss(input logic [MSS_W-1:0] value);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        sb.write_mss(value);
    endtask

    task automatic run_random(input int unsigned count);
        ack_mark = $urandom();
        dup_run  = 0;
        repeat (count)
            send_event(make_event());
    endtask

    // receiver stall bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 15) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // take every result beat the block hands over
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_beat.cwnd   = cong_window;
            seen_beat.ssth   = slow_start_thresh;
            seen_beat.recov  = in_recovery;
            seen_beat.rtx    = retransmit;
            seen_beat.usable = usable_window;
            sb.check_result(seen_beat);
        end
    end

    // watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned mss_plan [4];
        rst_n           = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_write_data  = '0;
        in_valid        = 1'b0;
        req_type        = tnr_pkg::REQ_ACK;
        ack_number      = '0;
        prev_ack_number = '0;
        dup_ack_count   = '0;
        peer_window     = '0;
        send_next_seq   = '0;
        idle_on         = 1'b0;
        stall_on        = 1'b0;
        n_events        = 0;
        quiet_cycles    = 0;
        ack_mark        = '0;
        dup_run         = 0;
        sb = new();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_on  = 1'b1;
        stall_on = 1'b1;

        // directed: slow start, repeated ack, few duplicates
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd100, 32'd0, 16'd0, ALL_ONES, 32'd5000));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd100, 32'd100, 16'd0, ALL_ONES, 32'd5000));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd100, 32'd100, 16'd1, 32'd4000, 32'd5000));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd100, 32'd100, 16'd2, 32'd4000, 32'd5000));
        // established with a small window, then grow past the threshold
        send_event(ev_of(tnr_pkg::REQ_EST, 32'd0, 32'd0, 16'd0, 32'd3000, 32'd0));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd200, 32'd100, 16'd0, 32'd3000, 32'd9000));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd300, 32'd200, 16'd0, 32'd3000, 32'd9000));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd400, 32'd300, 16'd0, 32'd3000, 32'd9000));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd500, 32'd400, 16'd0, 32'd3000, 32'd9000));
        // congestion avoidance
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd600, 32'd500, 16'd0, 32'd3000, 32'd9000));
        // third duplicate with a closed peer window, then later duplicates
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd600, 32'd600, 16'd3, 32'd0,
                         32'h8000_0100));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd600, 32'd600, 16'd4, 32'd1,
                         32'h8000_0200));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd600, 32'd600, 16'hFFFF, ALL_ONES,
                         32'hFFFF_FFFF));
        // partial acks with open and closed peer window, then recovery exit
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'h8000_0000, 32'd600, 16'd0, 32'd5,
                         32'h8000_0100));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'h8000_0001, 32'h8000_0000, 16'd0, 32'd0,
                         32'h8000_0100));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'h8000_0100, 32'h8000_0001, 16'd0, 32'd7000,
                         32'h8000_0100));
        // timeout and unknown event
        send_event(ev_of(tnr_pkg::REQ_TIMEOUT, 32'd0, 32'd0, 16'd0, 32'd9000, 32'd0));
        send_event(ev_of(REQ_UNKNOWN, '1, '1, '1, '1, '1));
        // recovery exit across sequence wrap
        send_event(ev_of(tnr_pkg::REQ_EST, 32'd0, 32'd0, 16'd0, 32'd0, 32'd0));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'hFFFF_FFE0, 32'hFFFF_FFE0, 16'd3, 32'hFFFF,
                         32'hFFFF_FFF0));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'h0000_0010, 32'hFFFF_FFE0, 16'd0, 32'hFFFF,
                         32'h0000_0100));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'h0000_0020, 32'h0000_0010, 16'd0, 32'hFFFF,
                         32'h0000_0100));
        drain();

        // zero segment size until established restores the default
        write_mss('0);
        send_event(ev_of(tnr_pkg::REQ_TIMEOUT, 32'd0, 32'd0, 16'd0, 32'd1000, 32'd0));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd40, 32'd20, 16'd0, 32'd1000, 32'd100));
        send_event(ev_of(tnr_pkg::REQ_EST, 32'd0, 32'd0, 16'd0, 32'd100000, 32'd0));
        drain();

        // random phases over several segment sizes
        mss_plan = '{1460, 1, 65535, $urandom_range(1, 65535)};
        foreach (mss_plan[i])
        begin
            write_mss(MSS_W'(mss_plan[i]));
            run_random(200);
            drain();
        end

        // largest segment: later duplicates grow the window a full segment each
        idle_on  = 1'b0;
        stall_on = 1'b0;
        write_mss('1);
        send_event(ev_of(tnr_pkg::REQ_EST, 32'd0, 32'd0, 16'd0, ALL_ONES, 32'd0));
        repeat (BIG_SEG_STEPS)
            send_event(ev_of(tnr_pkg::REQ_ACK, 32'd7, 32'd7,
                             DUPS_W'($urandom_range(4, 65535)), $urandom() | 32'd1,
                             $urandom()));
        send_event(ev_of(tnr_pkg::REQ_ACK, 32'd8, 32'd7, 16'd0, ALL_ONES, 32'd9));
        drain();

        // closing phase at the reset segment size, no idling
        write_mss(tnr_pkg::MSS_RESET);
        run_random(220);
        drain();
        repeat (60) @(posedge clk);

        $display("%0d events driven, %0d result beats checked, %0d mismatches",
                 n_events, sb.n_beats, sb.n_errors);
        $display("segment sizes 536, 0, 1460, 1, 65535, random; recovery, wrap, large segment");
        if (sb.n_errors == 0 && sb.due_windows.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tnr_pkg.sv
hdl/tnr_mul.sv
hdl/tnr_div.sv
hdl/tcp_newreno_congestion_window.sv
verif/tb_tcp_newreno_congestion_window.sv
